@@ rtl/register_file_alu_executor_core_macros.svh @@
// Assertion macros shared by the register file ALU executor RTL.
`ifndef REGISTER_FILE_ALU_EXECUTOR_CORE_MACROS_SVH
`define REGISTER_FILE_ALU_EXECUTOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset.
`define RFAE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rfae assertion failed");

// Next-cycle implication, checked out of reset.
`define RFAE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rfae assertion failed");

`else

`define RFAE_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define RFAE_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/rfae_pkg.sv @@
// Package with the types, constants and helper functions of the ALU executor.
`default_nettype none

package rfae_pkg;

    localparam int NUM_REGS  = 4;
    localparam int REG_AW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int IDX_W     = 2;
    localparam int MODE_W    = 4;
    localparam int DATA_W    = 32;
    localparam int ADD_W     = DATA_W + 2;
    localparam int CNT_W     = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(DATA_W - 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_IN   = 4'd0,
        MODE_OUT  = 4'd1,
        MODE_MOV  = 4'd2,
        MODE_XCHG = 4'd3,
        MODE_ADD  = 4'd4,
        MODE_SUB  = 4'd5,
        MODE_MUL  = 4'd6,
        MODE_DIV  = 4'd7,
        MODE_MOD  = 4'd8,
        MODE_AND  = 4'd9,
        MODE_OR   = 4'd10,
        MODE_XOR  = 4'd11
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_X,
        S_RD_Y,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_FIX,
        S_WB,
        S_WB2,
        S_OUT
    } state_t;

    // Register index taken modulo the file size. The field is below twice
    // the smallest file size, so one compare and subtract is enough.
    function automatic logic [REG_AW-1:0] reg_idx(input logic [IDX_W-1:0] f);
        logic [5:0] w;
        begin
            w = 6'(f);
            if (w >= 6'(NUM_REGS)) begin
                w = w - 6'(NUM_REGS);
            end
            return w[REG_AW-1:0];
        end
    endfunction

    function automatic logic [DATA_W-1:0] neg_val(input logic [DATA_W-1:0] v);
        return {DATA_W{1'b0}} - v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/register_file_alu_executor_core.sv @@
// Top level of the register file ALU executor: sequencer, register file and shared adder.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------------------
//  s_      | in        | s_valid / s_ready  | mode, dest, src_a, src_b, three_operand,
//          |           |                    | load_value
//  m_      | out       | m_valid / m_ready  | read_value
//
// IN goes straight from idle to write-back. OUT, MOV, ADD, SUB and the logic operations read two
// operands and execute; XCHG adds a second write-back. MUL and DIV or MOD loop once per bit through
// the shared adder (DIV and MOD then fix the signs); a DIV or MOD by zero skips that loop.
// Register reads go through a registered read port, one operand a cycle.
// Reset clears the valid bits of the register file, so every register reads as zero.
// s_ready is high only while the sequencer is idle; unused modes are taken and dropped.
// A result waits in the output register, and an OUT waits only while that register is full.
`default_nettype none

`include "register_file_alu_executor_core_macros.svh"

module register_file_alu_executor_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [rfae_pkg::MODE_W-1:0]         s_mode,
    input  wire logic [rfae_pkg::IDX_W-1:0]          s_dest,
    input  wire logic [rfae_pkg::IDX_W-1:0]          s_src_a,
    input  wire logic [rfae_pkg::IDX_W-1:0]          s_src_b,
    input  wire logic                                s_three_operand,
    input  wire logic signed [rfae_pkg::DATA_W-1:0]  s_load_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [rfae_pkg::DATA_W-1:0]       m_read_value
);

    import rfae_pkg::*;

    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [REG_AW-1:0]   d_reg, d_next;
    logic [REG_AW-1:0]   a_reg, a_next;
    logic [REG_AW-1:0]   b_reg, b_next;
    logic                three_reg, three_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    logic [DATA_W-1:0]   opx_reg, opx_next;
    logic [DATA_W-1:0]   opy_reg, opy_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                neg_q_reg, neg_q_next;
    logic                neg_r_reg, neg_r_next;
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   m_data_reg, m_data_next;

    logic [DATA_W-1:0]   mem [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    logic [DATA_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic [REG_AW-1:0]   mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [REG_AW-1:0]   mem_raddr;

    logic [ADD_W-1:0]    add_a, add_b, add_sum;
    logic                add_sub;

    logic                accept;
    logic                mode_used;
    logic                out_free;
    logic                step_last;
    logic                div_zero;
    logic [DATA_W-1:0]   op_x, op_y;

    assign accept    = s_valid && s_ready;
    assign mode_used = (s_mode <= MODE_W'(MODE_XOR));
    assign out_free  = !m_valid_reg || m_ready;
    assign step_last = (cnt_reg == STEP_LAST);
    assign op_x      = opx_reg;
    assign op_y      = rd_data_reg;
    assign div_zero  = (op_y == '0);

    // Shared adder: ALU add and subtract, multiply accumulate, divide trial subtract.
    assign add_sum = add_a + (add_sub ? ~add_b : add_b) + ADD_W'(add_sub);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && mode_used) begin
                    state_next = (s_mode == MODE_IN) ? S_WB : S_RD_X;
                end
            end
            S_RD_X: state_next = S_RD_Y;
            S_RD_Y: state_next = S_EXEC;
            S_EXEC: begin
                unique case (mode_reg) inside
                    MODE_OUT: state_next = S_OUT;
                    MODE_MUL: state_next = S_MUL;
                    MODE_DIV, MODE_MOD: state_next = div_zero ? S_WB : S_DIV;
                    default: state_next = S_WB;
                endcase
            end
            S_MUL: if (step_last) state_next = S_WB;
            S_DIV: if (step_last) state_next = S_FIX;
            S_FIX: state_next = S_WB;
            S_WB:  state_next = (mode_reg == MODE_XCHG) ? S_WB2 : S_IDLE;
            S_WB2: state_next = S_IDLE;
            S_OUT: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control outputs: handshake, register file ports and adder operands.
    always_comb begin
        s_ready   = (state_reg == S_IDLE);
        mem_we    = 1'b0;
        mem_waddr = d_reg;
        mem_wdata = acc_reg;
        mem_raddr = a_reg;
        add_a     = ADD_W'(op_x);
        add_b     = ADD_W'(op_y);
        add_sub   = 1'b0;
        unique case (state_reg)
            S_RD_X: begin
                if (mode_reg == MODE_MOV || (three_reg && mode_reg != MODE_OUT
                        && mode_reg != MODE_XCHG)) begin
                    mem_raddr = a_reg;
                end else begin
                    mem_raddr = d_reg;
                end
            end
            S_RD_Y: begin
                if (three_reg && mode_reg != MODE_XCHG) begin
                    mem_raddr = b_reg;
                end else begin
                    mem_raddr = a_reg;
                end
            end
            S_EXEC: begin
                add_sub = (mode_reg == MODE_SUB);
            end
            S_MUL: begin
                add_a = ADD_W'(acc_reg);
                add_b = ADD_W'(opx_reg);
            end
            S_DIV: begin
                add_a   = ADD_W'({acc_reg, opx_reg[DATA_W-1]});
                add_b   = ADD_W'(opy_reg);
                add_sub = 1'b1;
            end
            S_WB: begin
                mem_we = 1'b1;
            end
            S_WB2: begin
                mem_we    = 1'b1;
                mem_waddr = a_reg;
                mem_wdata = opx_reg;
            end
            default: begin
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        mode_next    = mode_reg;
        d_next       = d_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        three_next   = three_reg;
        acc_next     = acc_reg;
        opx_next     = opx_reg;
        opy_next     = opy_reg;
        cnt_next     = cnt_reg;
        neg_q_next   = neg_q_reg;
        neg_r_next   = neg_r_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    mode_next  = mode_t'(s_mode);
                    d_next     = reg_idx(s_dest);
                    a_next     = reg_idx(s_src_a);
                    b_next     = reg_idx(s_src_b);
                    three_next = s_three_operand;
                    acc_next   = s_load_value;
                end
            end
            S_RD_Y: begin
                opx_next = rd_data_reg;
            end
            S_EXEC: begin
                cnt_next = '0;
                case (mode_reg) inside
                    MODE_MOV: acc_next = op_x;
                    MODE_XCHG: acc_next = op_y;
                    MODE_ADD, MODE_SUB: acc_next = add_sum[DATA_W-1:0];
                    MODE_AND: acc_next = op_x & op_y;
                    MODE_OR:  acc_next = op_x | op_y;
                    MODE_XOR: acc_next = op_x ^ op_y;
                    MODE_MUL: begin
                        acc_next = '0;
                        opy_next = op_y;
                    end
                    MODE_DIV, MODE_MOD: begin
                        if (div_zero) begin
                            acc_next = (mode_reg == MODE_DIV) ? '1 : op_x;
                        end else begin
                            acc_next   = '0;
                            opx_next   = op_x[DATA_W-1] ? neg_val(op_x) : op_x;
                            opy_next   = op_y[DATA_W-1] ? neg_val(op_y) : op_y;
                            neg_q_next = op_x[DATA_W-1] ^ op_y[DATA_W-1];
                            neg_r_next = op_x[DATA_W-1];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_MUL: begin
                if (opy_reg[0]) begin
                    acc_next = add_sum[DATA_W-1:0];
                end
                opx_next = {opx_reg[DATA_W-2:0], 1'b0};
                opy_next = {1'b0, opy_reg[DATA_W-1:1]};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            S_DIV: begin
                // Restoring division: the partial remainder sits in acc_reg and the
                // quotient bits shift into opx_reg as the dividend shifts out.
                if (!add_sum[ADD_W-1]) begin
                    acc_next = add_sum[DATA_W-1:0];
                    opx_next = {opx_reg[DATA_W-2:0], 1'b1};
                end else begin
                    acc_next = {acc_reg[DATA_W-2:0], opx_reg[DATA_W-1]};
                    opx_next = {opx_reg[DATA_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
            S_FIX: begin
                if (mode_reg == MODE_DIV) begin
                    acc_next = neg_q_reg ? neg_val(opx_reg) : opx_reg;
                end else begin
                    acc_next = neg_r_reg ? neg_val(acc_reg) : acc_reg;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = opx_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            vld_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (mem_we) begin
                vld_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        d_reg      <= d_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        three_reg  <= three_next;
        acc_reg    <= acc_next;
        opx_reg    <= opx_next;
        opy_reg    <= opy_next;
        cnt_reg    <= cnt_next;
        neg_q_reg  <= neg_q_next;
        neg_r_reg  <= neg_r_next;
        m_data_reg <= m_data_next;
    end

    // Register file: one write port, one registered read port; entries never
    // written since reset read as zero.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= vld_reg[mem_raddr] ? mem[mem_raddr] : '0;
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_data_reg;

    `RFAE_ASSERT_IMPL(a_ready_only_idle, aclk, aresetn, s_ready, state_reg == S_IDLE)
    `RFAE_ASSERT_NEXT(a_mul_to_wb, aclk, aresetn, state_reg == S_MUL && step_last, state_reg == S_WB)
    `RFAE_ASSERT_NEXT(a_div_to_fix, aclk, aresetn, state_reg == S_DIV && step_last, state_reg == S_FIX)
    `RFAE_ASSERT_IMPL(a_rem_below_div, aclk, aresetn, state_reg == S_DIV, acc_reg < opy_reg)
    `RFAE_ASSERT_NEXT(a_out_waits, aclk, aresetn, state_reg == S_OUT && !out_free, state_reg == S_OUT)

endmodule

`default_nettype wire
